FILE: sv/pid_controller_clamped_unit_defines.svh
// assertion macros for the pid controller
`ifndef PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pidc same-cycle check failed");
// next-cycle implication
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidc next-cycle check failed");
`else
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INT_GAIN    = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_STEP_TIME   = 3'd3,
		REG_INTEG_FLOOR = 3'd4,
		REG_INTEG_CEIL  = 3'd5,
		REG_DRIVE_FLOOR = 3'd6,
		REG_DRIVE_CEIL  = 3'd7
	} pidc_reg_idx_t;

	// reset values
	localparam logic signed [15:0] PROP_GAIN_RST   = 16'sd358;
	localparam logic signed [15:0] INT_GAIN_RST    = 16'sd72;
	localparam logic signed [15:0] DERIV_GAIN_RST  = 16'sd1280;
	localparam logic        [15:0] STEP_TIME_RST   = 16'd655;
	localparam logic signed [23:0] INTEG_FLOOR_RST = -24'sd10240;
	localparam logic signed [23:0] INTEG_CEIL_RST  = 24'sd10240;
	localparam logic signed [15:0] DRIVE_FLOOR_RST = 16'sd0;
	localparam logic signed [15:0] DRIVE_CEIL_RST  = 16'sd25600;

	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] int_gain;
		logic signed [15:0] deriv_gain_per_step;
		logic        [15:0] step_time;
		logic signed [23:0] integral_floor;
		logic signed [23:0] integral_ceiling;
		logic signed [15:0] drive_floor;
		logic signed [15:0] drive_ceiling;
	} pidc_cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_err;
		logic mul_step;
		logic upd_integ;
		logic mul_ki;
		logic mul_kd;
		logic finish;
	} pidc_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_INTEG,
		ST_KI,
		ST_KD,
		ST_FINISH
	} pidc_state_t;

endpackage

`default_nettype wire

FILE: sv/pid_controller_clamped_unit.sv
// channel   | direction | beat contents (low bits first)
// s_axis    | in        | tdata: target[15:0], measured[31:16]
// m_axis    | out       | tdata: drive[15:0]
// cfg       | in        | cfg_index selects register, cfg_data holds its value
//
// an item passes through accept, four shared 18x24 multiplier passes, finish
// its result is registered in the finish step, after the four multiplier passes
// the next beat is taken once the previous result sits in the output register
// a stalled output holds the finish step until the register is free
// reset clears the integral and the last error and restores every register default
// config writes are taken every cycle and act at once, so they go between items
`default_nettype none

`include "pid_controller_clamped_unit_defines.svh"

module pid_controller_clamped_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [31:0]                      s_axis_tdata,  // target, measured
	// output stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [15:0]                           m_axis_tdata,  // drive
	// config write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pidc_pkg::*;

	pidc_cfg_t          cfg;
	pidc_cmd_t          cmd;
	logic signed [15:0] drive;

	// register file never stalls
	assign cfg_ready = 1'b1;

	pidc_cfg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// sequencer: load error, four multiplies, finish
	pidc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// error, integral, product and sum registers around one multiplier
	pidc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.target   ($signed(s_axis_tdata[15:0])),
		.measured ($signed(s_axis_tdata[31:16])),
		.drive    (drive)
	);

	assign m_axis_tdata = drive;

	// one item in flight: no new beat right after an accepted one
	`PIDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a fresh result honours ordered drive limits
	`PIDC_ASSERT_SAME(a_drive_in_limits, clk, arst_n,
		$rose(m_axis_tvalid) && $past(cfg.drive_floor <= cfg.drive_ceiling),
		(drive >= $past(cfg.drive_floor)) && (drive <= $past(cfg.drive_ceiling)))

endmodule

`default_nettype wire

FILE: sv/pidc_cfg_regs.sv
`default_nettype none

module pidc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  wr_data,
	output pidc_pkg::pidc_cfg_t                   cfg
);
	import pidc_pkg::*;

	pidc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain           <= PROP_GAIN_RST;
			cfg_q.int_gain            <= INT_GAIN_RST;
			cfg_q.deriv_gain_per_step <= DERIV_GAIN_RST;
			cfg_q.step_time           <= STEP_TIME_RST;
			cfg_q.integral_floor      <= INTEG_FLOOR_RST;
			cfg_q.integral_ceiling    <= INTEG_CEIL_RST;
			cfg_q.drive_floor         <= DRIVE_FLOOR_RST;
			cfg_q.drive_ceiling       <= DRIVE_CEIL_RST;
		end else if (wr_en) begin
			case (pidc_reg_idx_t'(wr_index))
				REG_PROP_GAIN:   cfg_q.prop_gain           <= wr_data[15:0];
				REG_INT_GAIN:    cfg_q.int_gain            <= wr_data[15:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain_per_step <= wr_data[15:0];
				REG_STEP_TIME:   cfg_q.step_time           <= wr_data[15:0];
				REG_INTEG_FLOOR: cfg_q.integral_floor      <= wr_data;
				REG_INTEG_CEIL:  cfg_q.integral_ceiling    <= wr_data;
				REG_DRIVE_FLOOR: cfg_q.drive_floor         <= wr_data[15:0];
				REG_DRIVE_CEIL:  cfg_q.drive_ceiling       <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/pidc_ctrl.sv
`default_nettype none

module pidc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pidc_pkg::pidc_cmd_t  cmd
);
	import pidc_pkg::*;

	pidc_state_t state_q;
	pidc_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_STEP;
			ST_STEP:   state_nxt = ST_INTEG;
			ST_INTEG:  state_nxt = ST_KI;
			ST_KI:     state_nxt = ST_KD;
			ST_KD:     state_nxt = ST_FINISH;
			ST_FINISH: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_err = in_valid;
			end
			ST_STEP:   cmd.mul_step  = 1'b1;
			ST_INTEG:  cmd.upd_integ = 1'b1;
			ST_KI:     cmd.mul_ki    = 1'b1;
			ST_KD:     cmd.mul_kd    = 1'b1;
			ST_FINISH: cmd.finish    = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/pidc_dp.sv
`default_nettype none

module pidc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pidc_pkg::pidc_cfg_t  cfg,
	input  wire pidc_pkg::pidc_cmd_t  cmd,
	input  wire logic signed [15:0]   target,
	input  wire logic signed [15:0]   measured,
	output logic signed [15:0]        drive
);
	import pidc_pkg::*;

	logic signed [16:0] err_q;
	logic signed [16:0] last_err_q;
	logic signed [23:0] integ_q;
	logic signed [41:0] prod_q;
	logic signed [41:0] sum_q;
	logic signed [15:0] drive_q;

	logic signed [17:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [41:0] mul_p;
	logic signed [17:0] err_diff;
	logic signed [25:0] integ_acc;
	logic signed [25:0] integ_lo;
	logic signed [25:0] integ_hi;
	logic signed [23:0] integ_new;
	logic signed [41:0] total;
	logic signed [33:0] total_sh;
	logic signed [33:0] drive_lo;
	logic signed [33:0] drive_hi;
	logic signed [15:0] drive_new;

	assign err_diff = {err_q[16], err_q} - {last_err_q[16], last_err_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_step) begin
			mul_a = {err_q[16], err_q};
			mul_b = $signed({8'd0, cfg.step_time});
		end else if (cmd.upd_integ) begin
			mul_a = {{2{cfg.prop_gain[15]}}, cfg.prop_gain};
			mul_b = {{7{err_q[16]}}, err_q};
		end else if (cmd.mul_ki) begin
			mul_a = {{2{cfg.int_gain[15]}}, cfg.int_gain};
			mul_b = integ_q;
		end else if (cmd.mul_kd) begin
			mul_a = err_diff;
			mul_b = {{8{cfg.deriv_gain_per_step[15]}}, cfg.deriv_gain_per_step};
		end
	end

	assign mul_p = mul_a * mul_b;

	// integral: add floor(err*dt / 2^16), then clamp
	assign integ_acc = {{2{integ_q[23]}}, integ_q} + prod_q[41:16];
	assign integ_lo  = {{2{cfg.integral_floor[23]}}, cfg.integral_floor};
	assign integ_hi  = {{2{cfg.integral_ceiling[23]}}, cfg.integral_ceiling};

	always_comb begin
		if (integ_acc < integ_lo) begin
			integ_new = cfg.integral_floor;
		end else if (integ_acc > integ_hi) begin
			integ_new = cfg.integral_ceiling;
		end else begin
			integ_new = integ_acc[23:0];
		end
	end

	// drive: floor of the full sum / 2^8, then clamp
	assign total    = sum_q + prod_q;
	assign total_sh = total[41:8];
	assign drive_lo = {{18{cfg.drive_floor[15]}}, cfg.drive_floor};
	assign drive_hi = {{18{cfg.drive_ceiling[15]}}, cfg.drive_ceiling};

	always_comb begin
		if (total_sh < drive_lo) begin
			drive_new = cfg.drive_floor;
		end else if (total_sh > drive_hi) begin
			drive_new = cfg.drive_ceiling;
		end else begin
			drive_new = total_sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_err_q <= '0;
		end else begin
			if (cmd.upd_integ) integ_q <= integ_new;
			if (cmd.finish)    last_err_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) err_q <= {target[15], target} - {measured[15], measured};
		if (cmd.mul_step || cmd.upd_integ || cmd.mul_ki || cmd.mul_kd) prod_q <= mul_p;
		if (cmd.mul_ki) sum_q <= prod_q;
		if (cmd.mul_kd) sum_q <= sum_q + prod_q;
		if (cmd.finish) drive_q <= drive_new;
	end

	assign drive = drive_q;

endmodule

`default_nettype wire
